// ===== design/chtfl_pkg.sv =====
// Shared types and codes for the chained hash table with free list.
package chtfl_pkg;

    // Operation codes carried on the opcode field
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIRST  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Field widths of the result word
    localparam int NODE_OUT_W  = 8;
    localparam int COUNT_OUT_W = 9;

    // Payload stored with each node
    typedef struct packed {
        logic [7:0]         kind;
        logic signed [31:0] offset;
        logic [31:0]        symbol;
        logic [63:0]        object;
    } payload_t;

endpackage

// ===== design/chained_hash_table_free_list.sv =====
// Top level: fixed-capacity chained hash table with a free list of nodes.
//
//  channel  | handshake          | word
//  ---------+--------------------+---------------------------------------------
//  s_       | s_valid / s_ready  | opcode, key, var_kind/offset/symbol/object
//  m_       | m_valid / m_ready  | status, node_index, out_*, entry_count
//
// One word at a time; a small sequencer drives one read and one write port
// on each node memory. Append pushes a node from the free chain; remove
// walks the bucket chain and frees the node on a hit; get-first scans the
// buckets in order; clear reruns the reset sweep. After reset a sweep
// rebuilds buckets and free chain, s_ready low.
// s_ready is low from accept until the result word is taken on m_.
module chained_hash_table_free_list #(
    parameter int TABLE_NODES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [31:0]          s_key,
    input  logic [7:0]           s_var_kind,
    input  logic signed [31:0]   s_var_offset,
    input  logic [31:0]          s_var_symbol,
    input  logic [63:0]          s_var_object,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [chtfl_pkg::NODE_OUT_W-1:0]  m_node_index,
    output logic [31:0]          m_out_key,
    output logic [7:0]           m_out_kind,
    output logic signed [31:0]   m_out_offset,
    output logic [31:0]          m_out_symbol,
    output logic [63:0]          m_out_object,
    output logic [chtfl_pkg::COUNT_OUT_W-1:0] m_entry_count
);

    localparam int IW = $clog2(TABLE_NODES);
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] NIL = LW'(TABLE_NODES);

    typedef enum logic [9:0] {
        S_INIT     = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_APP_WR   = 10'b0000000100,
        S_REM_HEAD = 10'b0000001000,
        S_REM_CMP  = 10'b0000010000,
        S_REM_FREE = 10'b0000100000,
        S_SCAN     = 10'b0001000000,
        S_DATA     = 10'b0010000000,
        S_RESP     = 10'b0100000000,
        S_SPARE    = 10'b1000000000
    } state_t;

    // Node memories
    logic [LW-1:0]            bucket_mem  [TABLE_NODES];
    logic [LW-1:0]            link_mem    [TABLE_NODES];
    logic [31:0]              key_mem     [TABLE_NODES];
    chtfl_pkg::payload_t      payload_mem [TABLE_NODES];

    logic [LW-1:0]            bkt_rdata_reg;
    logic [LW-1:0]            link_rdata_reg;
    logic [31:0]              key_rdata_reg;
    chtfl_pkg::payload_t      pay_rdata_reg;

    logic                     bkt_we,  link_we,  node_we;
    logic [IW-1:0]            bkt_waddr, link_waddr, node_waddr;
    logic [LW-1:0]            bkt_wdata, link_wdata;
    logic [IW-1:0]            bkt_raddr, link_raddr, node_raddr;

    // Control and working registers
    state_t                   state_reg, state_next;
    logic [IW-1:0]            sweep_reg, sweep_next;
    logic                     clr_resp_reg, clr_resp_next;
    logic [LW-1:0]            free_head_reg, free_head_next;
    logic [LW-1:0]            count_reg, count_next;
    logic [LW-1:0]            cur_reg, cur_next;
    logic [LW-1:0]            prev_reg, prev_next;
    logic [LW-1:0]            scan_reg, scan_next;
    logic                     pend_reg, pend_next;

    // Latched input word
    logic [31:0]              key_reg;
    chtfl_pkg::payload_t      pay_reg;

    // Result word
    logic                     m_valid_reg, m_valid_next;
    logic [1:0]               status_reg, status_next;
    logic [LW-1:0]            node_reg, node_next;
    logic [31:0]              okey_reg, okey_next;
    chtfl_pkg::payload_t      opay_reg, opay_next;

    logic                     accept;
    logic [IW-1:0]            bkt_sel;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign bkt_sel = key_reg[IW-1:0];

    // Memory ports: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (bkt_we) begin
            bucket_mem[bkt_waddr] <= bkt_wdata;
        end
        bkt_rdata_reg <= bucket_mem[bkt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[link_raddr];
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            key_mem[node_waddr]     <= key_reg;
            payload_mem[node_waddr] <= pay_reg;
        end
        key_rdata_reg <= key_mem[node_raddr];
        pay_rdata_reg <= payload_mem[node_raddr];
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        clr_resp_next  = clr_resp_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        m_valid_next   = m_valid_reg;
        status_next    = status_reg;
        node_next      = node_reg;
        okey_next      = okey_reg;
        opay_next      = opay_reg;

        bkt_we     = 1'b0;
        bkt_waddr  = bkt_sel;
        bkt_wdata  = NIL;
        link_we    = 1'b0;
        link_waddr = free_head_reg[IW-1:0];
        link_wdata = bkt_rdata_reg;
        node_we    = 1'b0;
        node_waddr = free_head_reg[IW-1:0];
        bkt_raddr  = s_key[IW-1:0];
        link_raddr = free_head_reg[IW-1:0];
        node_raddr = link_rdata_reg[IW-1:0];

        case (state_reg)
            // Rebuild empty buckets and the free chain, one node a cycle
            S_INIT: begin
                bkt_we     = 1'b1;
                bkt_waddr  = sweep_reg;
                bkt_wdata  = NIL;
                link_we    = 1'b1;
                link_waddr = sweep_reg;
                link_wdata = LW'(sweep_reg) + LW'(1);
                sweep_next = sweep_reg + IW'(1);
                if (sweep_reg == {IW{1'b1}}) begin
                    if (clr_resp_reg) begin
                        status_next  = chtfl_pkg::ST_OK;
                        node_next    = '0;
                        okey_next    = '0;
                        opay_next    = '0;
                        m_valid_next = 1'b1;
                        state_next   = S_RESP;
                    end else begin
                        state_next   = S_IDLE;
                    end
                end
            end

            // Wait for a word; bucket and free-chain reads run ahead
            S_IDLE: begin
                if (accept) begin
                    case (s_opcode)
                        chtfl_pkg::OP_APPEND: state_next = S_APP_WR;
                        chtfl_pkg::OP_REMOVE: state_next = S_REM_HEAD;
                        chtfl_pkg::OP_FIRST: begin
                            scan_next  = '0;
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                        default: begin
                            sweep_next     = '0;
                            clr_resp_next  = 1'b1;
                            free_head_next = '0;
                            count_next     = '0;
                            state_next     = S_INIT;
                        end
                    endcase
                end
            end

            // Pop the free head and push it on the bucket chain
            S_APP_WR: begin
                status_next  = chtfl_pkg::ST_FULL;
                node_next    = '0;
                okey_next    = '0;
                opay_next    = '0;
                m_valid_next = 1'b1;
                state_next   = S_RESP;
                if (!free_head_reg[IW]) begin
                    link_we        = 1'b1;
                    link_waddr     = free_head_reg[IW-1:0];
                    link_wdata     = bkt_rdata_reg;
                    bkt_we         = 1'b1;
                    bkt_waddr      = bkt_sel;
                    bkt_wdata      = free_head_reg;
                    node_we        = 1'b1;
                    node_waddr     = free_head_reg[IW-1:0];
                    free_head_next = link_rdata_reg;
                    count_next     = count_reg + LW'(1);
                    status_next    = chtfl_pkg::ST_OK;
                    node_next      = free_head_reg;
                end
            end

            // Start the chain walk at the bucket head
            S_REM_HEAD: begin
                link_raddr = bkt_rdata_reg[IW-1:0];
                node_raddr = bkt_rdata_reg[IW-1:0];
                prev_next  = NIL;
                cur_next   = bkt_rdata_reg;
                if (bkt_rdata_reg[IW]) begin
                    status_next  = chtfl_pkg::ST_NOT_FOUND;
                    node_next    = '0;
                    okey_next    = '0;
                    opay_next    = '0;
                    m_valid_next = 1'b1;
                    state_next   = S_RESP;
                end else begin
                    state_next   = S_REM_CMP;
                end
            end

            // Compare one chain node; unlink on a hit, else advance
            S_REM_CMP: begin
                link_raddr = link_rdata_reg[IW-1:0];
                node_raddr = link_rdata_reg[IW-1:0];
                if (key_rdata_reg == key_reg) begin
                    if (!prev_reg[IW]) begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg[IW-1:0];
                        link_wdata = link_rdata_reg;
                    end else begin
                        bkt_we     = 1'b1;
                        bkt_waddr  = bkt_sel;
                        bkt_wdata  = link_rdata_reg;
                    end
                    state_next = S_REM_FREE;
                end else if (link_rdata_reg[IW]) begin
                    status_next  = chtfl_pkg::ST_NOT_FOUND;
                    node_next    = '0;
                    okey_next    = '0;
                    opay_next    = '0;
                    m_valid_next = 1'b1;
                    state_next   = S_RESP;
                end else begin
                    prev_next = cur_reg;
                    cur_next  = link_rdata_reg;
                end
            end

            // Push the removed node on the free chain
            S_REM_FREE: begin
                link_we        = 1'b1;
                link_waddr     = cur_reg[IW-1:0];
                link_wdata     = free_head_reg;
                free_head_next = cur_reg;
                if (count_reg != '0) begin
                    count_next = count_reg - LW'(1);
                end
                status_next  = chtfl_pkg::ST_OK;
                node_next    = '0;
                okey_next    = '0;
                opay_next    = '0;
                m_valid_next = 1'b1;
                state_next   = S_RESP;
            end

            // Read one bucket a cycle, check the previous one
            S_SCAN: begin
                bkt_raddr  = scan_reg[IW-1:0];
                node_raddr = bkt_rdata_reg[IW-1:0];
                if (pend_reg && !bkt_rdata_reg[IW]) begin
                    node_next  = bkt_rdata_reg;
                    state_next = S_DATA;
                end else if (scan_reg == NIL) begin
                    status_next  = chtfl_pkg::ST_EMPTY;
                    node_next    = '0;
                    okey_next    = '0;
                    opay_next    = '0;
                    m_valid_next = 1'b1;
                    state_next   = S_RESP;
                end else begin
                    scan_next = scan_reg + LW'(1);
                    pend_next = 1'b1;
                end
            end

            // Report the first entry found
            S_DATA: begin
                status_next  = chtfl_pkg::ST_OK;
                okey_next    = key_rdata_reg;
                opay_next    = pay_rdata_reg;
                m_valid_next = 1'b1;
                state_next   = S_RESP;
            end

            // Hold the result word until taken
            S_RESP: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            clr_resp_reg  <= 1'b0;
            free_head_reg <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            clr_resp_reg  <= clr_resp_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        scan_reg   <= scan_next;
        pend_reg   <= pend_next;
        status_reg <= status_next;
        node_reg   <= node_next;
        okey_reg   <= okey_next;
        opay_reg   <= opay_next;
        if (accept) begin
            key_reg        <= s_key;
            pay_reg.kind   <= s_var_kind;
            pay_reg.offset <= s_var_offset;
            pay_reg.symbol <= s_var_symbol;
            pay_reg.object <= s_var_object;
        end
    end

    // Result word
    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_node_index  = chtfl_pkg::NODE_OUT_W'(node_reg);
    assign m_out_key     = okey_reg;
    assign m_out_kind    = opay_reg.kind;
    assign m_out_offset  = opay_reg.offset;
    assign m_out_symbol  = opay_reg.symbol;
    assign m_out_object  = opay_reg.object;
    assign m_entry_count = chtfl_pkg::COUNT_OUT_W'(count_reg);

endmodule
